// ===== rtl/core/ksh_pkg.sv =====
package ksh_pkg;

    // SipHash initialisation constants
    localparam logic [63:0] IV0 = 64'h736f6d6570736575;
    localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
    localparam logic [63:0] IV2 = 64'h6c7967656e657261;
    localparam logic [63:0] IV3 = 64'h7465646279746573;

    // length word (32 message bytes) and finalisation constant
    localparam logic [63:0] LEN_WORD  = 64'h2000000000000000;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

    // structure: record words, length word, compression and final rounds
    localparam int unsigned NUM_MSG    = 4;
    localparam int unsigned NUM_WORDS  = NUM_MSG + 1;
    localparam int unsigned C_ROUNDS   = 2;
    localparam int unsigned D_ROUNDS   = 4;
    localparam int unsigned ABS_ROUNDS = NUM_WORDS * C_ROUNDS;
    // each cell runs half a SipRound
    localparam int unsigned NUM_CELLS  = 2 * (ABS_ROUNDS + D_ROUNDS);

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LOW   = 2'd0,
        REG_KEY_HIGH  = 2'd1,
        REG_KEY_EPOCH = 2'd2,
        REG_VERSION   = 2'd3
    } t_cfg_reg;

    localparam logic [15:0] VERSION_RST = 16'd1;

    typedef logic [3:0][63:0] t_quad;

    // what moves from cell to cell: hash state plus the record words
    typedef struct packed {
        t_quad st;
        t_quad msg;
    } t_lane;

    function automatic logic [63:0] rotl(input logic [63:0] w, input int unsigned n);
        return (w << n) | (w >> (64 - n));
    endfunction

endpackage

// ===== rtl/core/ksh_cell.sv =====
module ksh_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ksh_pkg::t_lane i_lane,
    output logic          o_valid,
    output ksh_pkg::t_lane o_lane
);
    import ksh_pkg::*;

    // position of this cell in the round schedule
    localparam int unsigned RND    = IDX / 2;
    localparam bit          HALF_B = (IDX % 2) == 1;
    localparam bit          ABSORB = RND < ABS_ROUNDS;
    localparam int unsigned WI     = RND / C_ROUNDS;
    localparam bit          FIRST  = (RND % C_ROUNDS) == 0;
    localparam bit          LAST   = (RND % C_ROUNDS) == (C_ROUNDS - 1);
    localparam bit          INJ_PRE  = ABSORB && !HALF_B && FIRST;
    localparam bit          INJ_POST = ABSORB && HALF_B && LAST;
    localparam bit          FIN      = HALF_B && (RND == ABS_ROUNDS - 1);
    localparam bit          IS_MSG   = WI < NUM_MSG;
    localparam logic [1:0]  WSEL     = IS_MSG ? WI[1:0] : 2'd0;

    logic           r_valid;
    ksh_pkg::t_lane r_lane;
    ksh_pkg::t_lane n_lane;
    logic [63:0]    w;
    logic [63:0]    s0, s1, s2, s3;

    // word absorbed around this round pair
    assign w = IS_MSG ? i_lane.msg[WSEL] : LEN_WORD;

    // half SipRound with optional word injection and finalisation
    always_comb begin
        s0 = i_lane.st[0];
        s1 = i_lane.st[1];
        s2 = i_lane.st[2];
        s3 = i_lane.st[3];
        if (INJ_PRE) begin
            s3 = s3 ^ w;
        end
        if (!HALF_B) begin
            s0 = s0 + s1;
            s1 = rotl(s1, 13) ^ s0;
            s0 = rotl(s0, 32);
            s2 = s2 + s3;
            s3 = rotl(s3, 16) ^ s2;
        end else begin
            s0 = s0 + s3;
            s3 = rotl(s3, 21) ^ s0;
            s2 = s2 + s1;
            s1 = rotl(s1, 17) ^ s2;
            s2 = rotl(s2, 32);
        end
        if (INJ_POST) begin
            s0 = s0 ^ w;
        end
        if (FIN) begin
            s2 = s2 ^ FINAL_XOR;
        end
        n_lane.st[0] = s0;
        n_lane.st[1] = s1;
        n_lane.st[2] = s2;
        n_lane.st[3] = s3;
        n_lane.msg   = i_lane.msg;
    end

    // word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ===== rtl/core/keyed_reading_tag_siphash_unit.sv =====
// Keyed SipHash-2-4 tag of one measurement record.
// Input channel: a record word (energy count, timestamp, unit, domain and
// producer code) is taken at each rising edge with start high and busy low.
// busy is always low: a new record may be started in every cycle.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
// (key low, key high, key epoch, tag version); write only while idle.
// Key, epoch and version are sampled together with the record.
// Pipeline: one entry stage that seeds the state and packs the words,
// 28 half-round cells (10 absorb rounds, 4 final rounds), one output stage.
// The tag passes the entry stage, the cells and the output stage and is
// then on o_tag with o_valid high. Throughput: one tag per cycle.
// The receiver cannot stall: each tag is shown for exactly one cycle.
// Reset clears all valid flags (words in flight are dropped) and returns
// the keys and epoch to zero and the version to one.
module keyed_reading_tag_siphash_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [63:0]                     i_energy_count,
    input  logic [63:0]                     i_time_stamp,
    input  logic [31:0]                     i_unit_number,
    input  logic [31:0]                     i_domain_number,
    input  logic [15:0]                     i_producer_code,
    input  logic                            i_cfg_we,
    input  logic [ksh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [63:0]                     i_cfg_data,
    output logic                            o_valid,
    output logic [63:0]                     o_tag
);
    import ksh_pkg::*;

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic [31:0] r_key_epoch;
    logic [15:0] r_version;

    logic           accept;
    logic           r_in_valid;
    ksh_pkg::t_lane r_in_lane;
    ksh_pkg::t_lane n_in_lane;

    logic           vld  [NUM_CELLS+1];
    ksh_pkg::t_lane lane [NUM_CELLS+1];

    logic        r_out_valid;
    logic [63:0] r_tag;
    logic [63:0] n_tag;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_key_epoch <= '0;
            r_version   <= VERSION_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_KEY_LOW:   r_key_low   <= i_cfg_data;
                REG_KEY_HIGH:  r_key_high  <= i_cfg_data;
                REG_KEY_EPOCH: r_key_epoch <= i_cfg_data[31:0];
                REG_VERSION:   r_version   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // entry stage: seed the state from the key, pack the record words
    always_comb begin
        n_in_lane.st[0]  = IV0 ^ r_key_low;
        n_in_lane.st[1]  = IV1 ^ r_key_high;
        n_in_lane.st[2]  = IV2 ^ r_key_low;
        n_in_lane.st[3]  = IV3 ^ r_key_high;
        n_in_lane.msg[0] = i_energy_count;
        n_in_lane.msg[1] = i_time_stamp;
        n_in_lane.msg[2] = {i_domain_number, i_unit_number};
        n_in_lane.msg[3] = {r_key_epoch, i_producer_code, r_version};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_lane <= n_in_lane;
    end

    assign vld[0]  = r_in_valid;
    assign lane[0] = r_in_lane;

    // chain of half-round cells
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        ksh_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[g]),
            .i_lane  (lane[g]),
            .o_valid (vld[g+1]),
            .o_lane  (lane[g+1])
        );
    end

    // output stage: fold the four state words
    assign n_tag = lane[NUM_CELLS].st[0] ^ lane[NUM_CELLS].st[1]
                 ^ lane[NUM_CELLS].st[2] ^ lane[NUM_CELLS].st[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= vld[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    assign o_valid = r_out_valid;
    assign o_tag   = r_tag;

endmodule
